// ===== design/mcr_pkg.sv =====
// Package for the midpoint circle rasterizer: widths, command codes and the
// step-job word passed from the front end to the pixel back end.
// No dependencies.
package mcr_pkg;

	localparam int COORD_W  = 16;              // center coordinate width
	localparam int PIX_W    = COORD_W + 1;     // plotted pixel coordinate width
	localparam int RAD_W    = COORD_W - 1;     // radius and walker x/y width
	localparam int DEC_W    = COORD_W + 2;     // decision variable width
	localparam int QDEPTH   = 4;               // step queue entries
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);
	localparam int NPIX     = 8;               // pixels per step
	localparam int PHASE_W  = $clog2(NPIX);

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	// Midpoint increments for the east and south-east moves.
	localparam logic [DEC_W-1:0] DEC_INC_E  = DEC_W'(3);
	localparam logic [DEC_W-1:0] DEC_INC_SE = DEC_W'(5);

	// One octant step ready for plotting.
	typedef struct packed {
		logic [COORD_W-1:0] h;
		logic [COORD_W-1:0] k;
		logic [RAD_W-1:0]   x;
		logic [RAD_W-1:0]   y;
		logic               done;
	} mcr_job_t;

endpackage

// ===== design/mcr_front.sv =====
// Front end of the rasterizer: accepts commands, holds the circle walker
// state and turns each advance on an active circle into one step word.
// Depends on mcr_pkg.
module mcr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic signed [mcr_pkg::COORD_W-1:0] center_x,
	input  logic signed [mcr_pkg::COORD_W-1:0] center_y,
	input  logic [mcr_pkg::RAD_W-1:0]     radius,
	input  logic                          q_full,
	output logic                          q_push,
	output mcr_pkg::mcr_job_t             q_data
);
	import mcr_pkg::*;

	logic [COORD_W-1:0] h_q, k_q;
	logic [RAD_W-1:0]   x_q, y_q;
	logic [DEC_W-1:0]   d_q;
	logic               active_q;

	logic               accept, more;
	logic [DEC_W-1:0]   x_ext, y_ext, d_next;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign more     = y_q > x_q;

	assign x_ext = {{(DEC_W-RAD_W){1'b0}}, x_q};
	assign y_ext = {{(DEC_W-RAD_W){1'b0}}, y_q};

	// A negative decision keeps y; otherwise the walker moves diagonally.
	assign d_next = d_q[DEC_W-1] ? (d_q + (x_ext << 1) + DEC_INC_E)
	                             : (d_q + ((x_ext - y_ext) << 1) + DEC_INC_SE);

	assign q_push      = accept && (command == CMD_ADVANCE) && active_q;
	assign q_data.h    = h_q;
	assign q_data.k    = k_q;
	assign q_data.x    = x_q;
	assign q_data.y    = y_q;
	assign q_data.done = !more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q      <= '0;
			k_q      <= '0;
			x_q      <= '0;
			y_q      <= '0;
			d_q      <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (command == CMD_START) begin
				h_q      <= center_x;
				k_q      <= center_y;
				x_q      <= '0;
				y_q      <= radius;
				d_q      <= DEC_W'(1) - {{(DEC_W-RAD_W){1'b0}}, radius};
				active_q <= 1'b1;
			end else if (active_q) begin
				if (more) begin
					d_q <= d_next;
					x_q <= x_q + RAD_W'(1);
					if (!d_q[DEC_W-1]) begin
						y_q <= y_q - RAD_W'(1);
					end
				end else begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== design/mcr_queue.sv =====
// Short step queue between the rasterizer front and back ends.
// Depends on mcr_pkg.
module mcr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mcr_pkg::mcr_job_t wdata,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output mcr_pkg::mcr_job_t rdata
);
	import mcr_pkg::*;

	mcr_job_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full  = cnt_q == QCNT_W'(QDEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== design/mcr_back.sv =====
// Back end of the rasterizer: takes one step word at a time and emits its
// eight mirrored pixels through a registered output, one word per cycle while out_ready is high.
// Depends on mcr_pkg.
module mcr_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  mcr_pkg::mcr_job_t                q_data,
	output logic                             q_pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [mcr_pkg::PIX_W-1:0] pixel_x,
	output logic signed [mcr_pkg::PIX_W-1:0] pixel_y,
	output logic                             last_of_step,
	output logic                             circle_done
);
	import mcr_pkg::*;

	mcr_job_t            job_q;
	logic                busy_q;
	logic [PHASE_W-1:0]  phase_q;
	logic                out_valid_q;
	logic [PIX_W-1:0]    pixel_x_q, pixel_y_q;
	logic                last_q, done_q;

	logic                emit, final_pix;
	logic [RAD_W-1:0]    ax, ay;
	logic [PIX_W-1:0]    h_ext, k_ext, ax_ext, ay_ext, px, py;

	assign emit      = busy_q && (!out_valid_q || out_ready);
	assign final_pix = phase_q == PHASE_W'(NPIX - 1);
	assign q_pop     = !q_empty && (!busy_q || (emit && final_pix));

	// Phases 4 to 7 swap x and y; bit 0 mirrors x, bit 1 mirrors y.
	assign ax     = phase_q[2] ? job_q.y : job_q.x;
	assign ay     = phase_q[2] ? job_q.x : job_q.y;
	assign h_ext  = {job_q.h[COORD_W-1], job_q.h};
	assign k_ext  = {job_q.k[COORD_W-1], job_q.k};
	assign ax_ext = {{(PIX_W-RAD_W){1'b0}}, ax};
	assign ay_ext = {{(PIX_W-RAD_W){1'b0}}, ay};
	assign px     = phase_q[0] ? (h_ext - ax_ext) : (h_ext + ax_ext);
	assign py     = phase_q[1] ? (k_ext - ay_ext) : (k_ext + ay_ext);

	assign out_valid    = out_valid_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign last_of_step = last_q;
	assign circle_done  = done_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
		end
		if (emit) begin
			pixel_x_q <= px;
			pixel_y_q <= py;
			last_q    <= final_pix;
			done_q    <= job_q.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_q + PHASE_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (emit && final_pix) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/midpoint_circle_rasterizer_unit.sv =====
// Midpoint circle rasterizer top level: front end, step queue, pixel back end.
// Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.

// A start word loads center and radius and produces nothing. Each advance word
// on an active circle produces eight pixel words, one per cycle while out_ready
// is high, through the single pixel output register. Advances on an idle circle
// produce nothing. The front end runs the walker ahead and parks up to four
// pending steps in a queue, so input is taken at one word per cycle until that
// queue fills.
module midpoint_circle_rasterizer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              command,
	input  logic signed [mcr_pkg::COORD_W-1:0] center_x,
	input  logic signed [mcr_pkg::COORD_W-1:0] center_y,
	input  logic [mcr_pkg::RAD_W-1:0]         radius,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mcr_pkg::PIX_W-1:0]  pixel_x,
	output logic signed [mcr_pkg::PIX_W-1:0]  pixel_y,
	output logic                              last_of_step,
	output logic                              circle_done
);
	import mcr_pkg::*;

	logic     q_full, q_empty, q_push, q_pop;
	mcr_job_t q_wdata, q_rdata;

	mcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	mcr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	mcr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last_of_step (last_of_step),
		.circle_done  (circle_done)
	);

endmodule

// ===== tb/sv/midpoint_circle_rasterizer_unit_tb.sv =====
// Testbench for midpoint_circle_rasterizer_unit: directed and random command
// words, checked pixel by pixel against an in-bench model of the midpoint walker.
// Depends on mcr_pkg and the rasterizer RTL.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_unit_tb;
	import mcr_pkg::*;

	typedef struct {
		logic signed [PIX_W-1:0] px;
		logic signed [PIX_W-1:0] py;
		logic                    last;
		logic                    done;
	} pixel_word_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      command;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic [RAD_W-1:0]          radius;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [PIX_W-1:0]   pixel_x;
	logic signed [PIX_W-1:0]   pixel_y;
	logic                      last_of_step;
	logic                      circle_done;

	// Model of the walker and the pixels it still owes.
	logic signed [COORD_W-1:0] hold_cx;
	logic signed [COORD_W-1:0] hold_cy;
	logic [RAD_W-1:0]          walk_x;
	logic [RAD_W-1:0]          walk_y;
	logic signed [DEC_W-1:0]   walk_d;
	bit                        walk_active;
	pixel_word_t               pending_pixels[$];

	bit steady;           // no idling on either side while set
	int error_count;
	int starts_sent;
	int advances_sent;
	int busy_words;       // starts plus advances on an active circle
	int circles_closed;
	int pixels_checked;

	midpoint_circle_rasterizer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.last_of_step(last_of_step),
		.circle_done(circle_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit idle_now();
		return !steady && ($urandom_range(0, 99) < 27);
	endfunction

	always @(negedge clk) begin
		out_ready <= !idle_now();
	end

	task automatic report_mismatch(input string field, input int got, input int want);
		error_count++;
		$display("MISMATCH %s: got %0d, expected %0d (pixel %0d)", field, got, want,
			pixels_checked);
	endtask

	// Walker model: a start reloads it, an advance on an active circle owes eight pixels.
	task automatic predict_word(input logic cmd, input logic signed [COORD_W-1:0] cx,
			input logic signed [COORD_W-1:0] cy, input logic [RAD_W-1:0] r);
		logic signed [PIX_W-1:0] h, k, sx, sy;
		logic signed [PIX_W-1:0] ex[NPIX];
		logic signed [PIX_W-1:0] ey[NPIX];
		pixel_word_t w;
		bit finished;
		int d;
		if (cmd == CMD_START) begin
			hold_cx = cx;
			hold_cy = cy;
			walk_x = '0;
			walk_y = r;
			walk_d = DEC_W'(1 - int'(r));
			walk_active = 1'b1;
			starts_sent++;
			busy_words++;
		end else begin
			advances_sent++;
			if (walk_active) begin
				busy_words++;
				h = hold_cx;
				k = hold_cy;
				sx = $signed({2'b00, walk_x});
				sy = $signed({2'b00, walk_y});
				ex[0] = h + sx; ey[0] = k + sy;
				ex[1] = h - sx; ey[1] = k + sy;
				ex[2] = h + sx; ey[2] = k - sy;
				ex[3] = h - sx; ey[3] = k - sy;
				ex[4] = h + sy; ey[4] = k + sx;
				ex[5] = h - sy; ey[5] = k + sx;
				ex[6] = h + sy; ey[6] = k - sx;
				ex[7] = h - sy; ey[7] = k - sx;
				finished = !(walk_y > walk_x);
				if (!finished) begin
					d = walk_d;
					if (d < 0) begin
						d += 2 * int'(walk_x) + 3;
					end else begin
						d += 2 * (int'(walk_x) - int'(walk_y)) + 5;
						walk_y = walk_y - RAD_W'(1);
					end
					walk_x = walk_x + RAD_W'(1);
					walk_d = DEC_W'(d);
				end else begin
					walk_active = 1'b0;
					circles_closed++;
				end
				for (int i = 0; i < NPIX; i++) begin
					w.px = ex[i];
					w.py = ey[i];
					w.last = (i == NPIX - 1);
					w.done = finished;
					pending_pixels.push_back(w);
				end
			end
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(input logic cmd, input logic signed [COORD_W-1:0] cx,
			input logic signed [COORD_W-1:0] cy, input logic [RAD_W-1:0] r);
		int gap;
		if (idle_now()) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		center_x <= cx;
		center_y <= cy;
		radius <= r;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_word(cmd, cx, cy, r);
		@(negedge clk);
	endtask

	task automatic send_advance();
		send_word(CMD_ADVANCE, COORD_W'($urandom), COORD_W'($urandom), RAD_W'($urandom));
	endtask

	task automatic run_to_end(input int extra);
		while (walk_active) send_advance();
		repeat (extra) send_advance();
	endtask

	task automatic drain_pixels();
		in_valid <= 1'b0;
		for (int n = 0; n < 50000 && pending_pixels.size() != 0; n++) @(negedge clk);
		repeat (16) @(negedge clk);
		if (pending_pixels.size() != 0) begin
			report_mismatch("pixels never arrived", pending_pixels.size(), 0);
			pending_pixels.delete();
		end
	endtask

	always @(posedge clk) begin
		pixel_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected pixel_x", pixel_x, 0);
			end else begin
				w = pending_pixels.pop_front();
				if (pixel_x !== w.px) report_mismatch("pixel_x", pixel_x, w.px);
				if (pixel_y !== w.py) report_mismatch("pixel_y", pixel_y, w.py);
				if (last_of_step !== w.last)
					report_mismatch("last_of_step", last_of_step, w.last);
				if (circle_done !== w.done)
					report_mismatch("circle_done", circle_done, w.done);
				pixels_checked++;
			end
		end
	end

	task automatic test_advance_while_idle();
		send_advance();
		send_advance();
		drain_pixels();
	endtask

	// A zero radius plots the center eight times and closes at once.
	task automatic test_zero_radius();
		send_word(CMD_START, 16'sd0, 16'sd0, 15'd0);
		run_to_end(1);
		drain_pixels();
	endtask

	// Largest radius at both corners, then a start that abandons the running circle.
	task automatic test_extremes();
		send_word(CMD_START, 16'sh7fff, 16'sh7fff, 15'h7fff);
		repeat (3) send_advance();
		send_word(CMD_START, -16'sh8000, -16'sh8000, 15'h7fff);
		repeat (2) send_advance();
		send_word(CMD_START, -16'sh8000, 16'sh7fff, 15'd1);
		run_to_end(0);
		drain_pixels();
	endtask

	task automatic test_small_circle();
		send_word(CMD_START, 16'sd100, -16'sd200, 15'd5);
		run_to_end(1);
		drain_pixels();
	endtask

	task automatic random_center(output logic signed [COORD_W-1:0] c);
		case ($urandom_range(0, 5))
			0: c = 16'sh7fff;
			1: c = -16'sh8000;
			default: c = COORD_W'($urandom);
		endcase
	endtask

	task automatic test_random();
		logic signed [COORD_W-1:0] cx, cy;
		logic [RAD_W-1:0] r;
		int base, pick, seq;
		base = busy_words;
		seq = 0;
		while (busy_words - base < 220) begin
			steady = (seq >= 8 && seq < 14);
			random_center(cx);
			random_center(cy);
			pick = $urandom_range(0, 99);
			if (pick < 70) r = RAD_W'($urandom_range(0, 24));
			else if (pick < 88) r = RAD_W'($urandom_range(25, 60));
			else r = RAD_W'($urandom);
			send_word(CMD_START, cx, cy, r);
			pick = $urandom_range(0, 99);
			if (pick < 75 && r <= 60) begin
				run_to_end($urandom_range(0, 2));
			end else if (pick < 90) begin
				// Abandon part way through.
				repeat ($urandom_range(0, 6)) send_advance();
			end else begin
				send_word(CMD_START, COORD_W'($urandom), COORD_W'($urandom),
					RAD_W'($urandom_range(0, 12)));
				run_to_end(0);
			end
			seq++;
		end
		steady = 1'b0;
		drain_pixels();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_START;
		center_x = '0;
		center_y = '0;
		radius = '0;
		out_ready = 1'b0;
		steady = 1'b0;
		walk_active = 1'b0;
		hold_cx = '0;
		hold_cy = '0;
		walk_x = '0;
		walk_y = '0;
		walk_d = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_advance_while_idle();
		test_zero_radius();
		test_extremes();
		test_small_circle();
		test_random();
		$display("Covered %0d starts and %0d advances, %0d circles closed.",
			starts_sent, advances_sent, circles_closed);
		$display("Checked %0d pixels, %0d mismatches.", pixels_checked, error_count);
		if (error_count == 0) begin
			$display("midpoint_circle_rasterizer_unit_tb passed");
		end else begin
			$display("midpoint_circle_rasterizer_unit_tb failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Timeout with %0d pixels outstanding.", pending_pixels.size());
		$display("midpoint_circle_rasterizer_unit_tb failed");
		$finish;
	end

endmodule
